// File: sv/atq_pkg.sv
`timescale 1ns / 1ps

package atq_pkg;

  localparam int DepthDefault = 16;
  localparam int LinkCount    = 8;

  localparam logic [15:0] AckTimeoutReset = 16'd2000;
  localparam logic [15:0] RetryDelayReset = 16'd100;
  localparam logic [3:0]  MaxResendsReset = 4'd2;
  localparam logic [15:0] NoreplyIdReset  = 16'd0;

  localparam logic [15:0] NoreplyNextTicks = 16'd1;
  localparam logic [3:0]  ResendMax        = 4'd15;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_ACK   = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_ACK_TIMEOUT = 2'd0,
    CFG_RETRY_DELAY = 2'd1,
    CFG_MAX_RESENDS = 2'd2,
    CFG_NOREPLY_ID  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] pkt_id;
    logic [15:0] pkt_len;
    logic [2:0]  link_num;
    logic        link_connected;
    logic        link_credit;
    logic        link_vendor;
    logic        send_ok;
  } in_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [3:0]  send_slot;
    logic [2:0]  send_link;
    logic [15:0] send_id;
    logic [15:0] send_len;
    logic        send_vendor_channel;
    logic        push_accepted;
    logic        queue_empty;
    logic        awaiting_ack;
  } out_item_t;

  // Descriptor as kept in the slot RAM
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] len;
    logic [2:0]  link;
  } slot_t;

  localparam int SlotW = $bits(slot_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_OFFER,
    S_OUT
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_PUSH,
    CMD_TICK_DEC,
    CMD_EXPIRE,
    CMD_CLEAR,
    CMD_RELEASE,
    CMD_NOCREDIT,
    CMD_RETRY,
    CMD_SEND
  } cmd_e;

  typedef struct packed {
    action_e act;
    logic    push_ok;
    logic    head_valid;
    logic    timer_run;
    logic    timer_last;
    logic    release_head;
    logic    waiting;
    logic    connected;
    logic    credit;
    logic    send_ok;
  } ctl_status_t;

endpackage

// File: sv/atq_ram.sv
`timescale 1ns / 1ps

module atq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/atq_ctrl.sv
`timescale 1ns / 1ps

module atq_ctrl import atq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  ctl_status_t status_i,
  output cmd_e        cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_OUT;
        unique case (status_i.act)
          ACT_PUSH: begin
            if (status_i.push_ok) begin
              cmd_o   = CMD_PUSH;
              state_d = S_READ;
            end
          end
          ACT_ACK: begin
            if (status_i.head_valid) begin
              state_d = S_READ;
            end
          end
          ACT_TICK: begin
            if (status_i.timer_run) begin
              if (!status_i.timer_last) begin
                cmd_o = CMD_TICK_DEC;
              end else begin
                cmd_o = CMD_EXPIRE;
                if (status_i.head_valid) begin
                  state_d = S_READ;
                end
              end
            end
          end
          ACT_CLEAR: cmd_o = CMD_CLEAR;
          default: state_d = S_OUT;
        endcase
      end
      // Head descriptor arrives from the RAM at the end of this cycle
      S_READ: state_d = S_OFFER;
      S_OFFER: begin
        state_d = S_OUT;
        if (status_i.head_valid) begin
          if (status_i.release_head) begin
            // Drop the head, then offer the next one
            cmd_o   = CMD_RELEASE;
            state_d = S_READ;
          end else if (status_i.waiting || !status_i.connected) begin
            cmd_o = CMD_NONE;
          end else if (!status_i.credit) begin
            cmd_o = CMD_NOCREDIT;
          end else if (!status_i.send_ok) begin
            cmd_o = CMD_RETRY;
          end else begin
            cmd_o = CMD_SEND;
          end
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: sv/atq_datapath.sv
`timescale 1ns / 1ps

module atq_datapath import atq_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_item_i,
  input  cmd_e        cmd_i,
  output ctl_status_t status_o,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  cfg_idx_e    cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LastPos = AW'(DEPTH - 1);

  // Configuration
  logic [15:0] cfg_ack_q, cfg_retry_q, cfg_noreply_q;
  logic [3:0]  cfg_max_q;

  // Queue control
  logic [DEPTH-1:0] valid_q, valid_d;
  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [3:0]       resend_q, resend_d;
  logic             waiting_q, waiting_d;
  logic [15:0]      timer_left_q, timer_left_d;
  logic             timer_ack_q, timer_ack_d;
  logic             timer_run_q, timer_run_d;
  logic             rel_q, rel_d;
  logic             cmp_q, cmp_d;

  // Item and result payload
  in_item_t    in_q;
  logic        accepted_q;
  logic        sent_q;
  logic [3:0]  sent_slot_q;
  logic [2:0]  sent_link_q;
  logic [15:0] sent_id_q, sent_len_q;
  logic        sent_chan_q;

  slot_t       head;
  logic [SlotW-1:0] ram_rdata;
  logic [3:0]  resend_inc;
  logic [AW-1:0] rp_next, wp_next;

  atq_ram #(
    .WIDTH (SlotW),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i == CMD_PUSH),
    .waddr_i (wp_q),
    .wdata_i ({in_q.pkt_id, in_q.pkt_len, in_q.link_num}),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  assign head       = slot_t'(ram_rdata);
  assign rp_next    = (rp_q == LastPos) ? '0 : rp_q + 1'b1;
  assign wp_next    = (wp_q == LastPos) ? '0 : wp_q + 1'b1;
  assign resend_inc = (resend_q < ResendMax) ? resend_q + 4'd1 : resend_q;

  always_comb begin
    status_o.act          = action_e'(in_q.action);
    status_o.push_ok      = !valid_q[wp_q] && (32'(in_q.link_num) < 32'(LinkCount));
    status_o.head_valid   = valid_q[rp_q];
    status_o.timer_run    = timer_run_q;
    status_o.timer_last   = (timer_left_q <= 16'd1);
    status_o.release_head = rel_q || (cmp_q && (head.id == in_q.pkt_id));
    status_o.waiting      = waiting_q;
    status_o.connected    = in_q.link_connected;
    status_o.credit       = in_q.link_credit;
    status_o.send_ok      = in_q.send_ok;
  end

  always_comb begin
    valid_d      = valid_q;
    wp_d         = wp_q;
    rp_d         = rp_q;
    resend_d     = resend_q;
    waiting_d    = waiting_q;
    timer_left_d = timer_left_q;
    timer_ack_d  = timer_ack_q;
    timer_run_d  = timer_run_q;
    rel_d        = rel_q;
    cmp_d        = cmp_q;
    unique case (cmd_i)
      CMD_LOAD: begin
        rel_d = 1'b0;
        cmp_d = (in_item_i.action == ACT_ACK);
      end
      CMD_PUSH: begin
        valid_d[wp_q] = 1'b1;
        wp_d          = wp_next;
      end
      CMD_TICK_DEC: timer_left_d = timer_left_q - 16'd1;
      CMD_EXPIRE: begin
        timer_run_d  = 1'b0;
        timer_left_d = '0;
        waiting_d    = 1'b0;
        if (valid_q[rp_q] && timer_ack_q) begin
          resend_d = resend_inc;
          rel_d    = (resend_inc >= cfg_max_q);
        end
      end
      CMD_CLEAR: begin
        timer_run_d  = 1'b0;
        timer_left_d = '0;
        timer_ack_d  = 1'b0;
        valid_d      = '0;
        wp_d         = '0;
        rp_d         = '0;
        resend_d     = '0;
        waiting_d    = 1'b0;
      end
      CMD_RELEASE: begin
        timer_run_d   = 1'b0;
        timer_left_d  = '0;
        valid_d[rp_q] = 1'b0;
        rp_d          = rp_next;
        resend_d      = '0;
        waiting_d     = 1'b0;
        rel_d         = 1'b0;
        cmp_d         = 1'b0;
      end
      CMD_NOCREDIT: begin
        valid_d[rp_q] = 1'b0;
        rp_d          = rp_next;
        resend_d      = '0;
        timer_run_d   = 1'b1;
        timer_left_d  = NoreplyNextTicks;
        timer_ack_d   = 1'b0;
      end
      CMD_RETRY: begin
        timer_run_d  = 1'b1;
        timer_left_d = cfg_retry_q;
        timer_ack_d  = 1'b0;
      end
      CMD_SEND: begin
        timer_run_d = 1'b1;
        if (head.id == cfg_noreply_q) begin
          // No acknowledge expected: release at once
          valid_d[rp_q] = 1'b0;
          rp_d          = rp_next;
          timer_left_d  = NoreplyNextTicks;
          timer_ack_d   = 1'b0;
        end else begin
          waiting_d    = 1'b1;
          timer_left_d = cfg_ack_q;
          timer_ack_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      wp_q          <= '0;
      rp_q          <= '0;
      resend_q      <= '0;
      waiting_q     <= 1'b0;
      timer_left_q  <= '0;
      timer_ack_q   <= 1'b0;
      timer_run_q   <= 1'b0;
      rel_q         <= 1'b0;
      cmp_q         <= 1'b0;
      cfg_ack_q     <= AckTimeoutReset;
      cfg_retry_q   <= RetryDelayReset;
      cfg_max_q     <= MaxResendsReset;
      cfg_noreply_q <= NoreplyIdReset;
    end else begin
      valid_q      <= valid_d;
      wp_q         <= wp_d;
      rp_q         <= rp_d;
      resend_q     <= resend_d;
      waiting_q    <= waiting_d;
      timer_left_q <= timer_left_d;
      timer_ack_q  <= timer_ack_d;
      timer_run_q  <= timer_run_d;
      rel_q        <= rel_d;
      cmp_q        <= cmp_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ACK_TIMEOUT: cfg_ack_q     <= cfg_wdata_i;
          CFG_RETRY_DELAY: cfg_retry_q   <= cfg_wdata_i;
          CFG_MAX_RESENDS: cfg_max_q     <= cfg_wdata_i[3:0];
          CFG_NOREPLY_ID:  cfg_noreply_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD) begin
      in_q        <= in_item_i;
      accepted_q  <= 1'b0;
      sent_q      <= 1'b0;
      sent_slot_q <= '0;
      sent_link_q <= '0;
      sent_id_q   <= '0;
      sent_len_q  <= '0;
      sent_chan_q <= 1'b0;
    end
    if (cmd_i == CMD_PUSH) begin
      accepted_q <= 1'b1;
    end
    if (cmd_i == CMD_SEND) begin
      sent_q      <= 1'b1;
      sent_slot_q <= 4'(rp_q);
      sent_link_q <= head.link;
      sent_id_q   <= head.id;
      sent_len_q  <= head.len;
      sent_chan_q <= in_q.link_vendor;
    end
  end

  always_comb begin
    out_item_o.send_valid          = sent_q;
    out_item_o.send_slot           = sent_slot_q;
    out_item_o.send_link           = sent_link_q;
    out_item_o.send_id             = sent_id_q;
    out_item_o.send_len            = sent_len_q;
    out_item_o.send_vendor_channel = sent_chan_q;
    out_item_o.push_accepted       = accepted_q;
    out_item_o.queue_empty         = !valid_q[rp_q];
    out_item_o.awaiting_ack        = waiting_q;
  end

endmodule

// File: sv/acked_transmit_queue_core.sv
`timescale 1ns / 1ps
// Sequence: an accepted item passes S_DISPATCH and then S_OUT when no head is
// offered (refused push, empty head, plain tick, clear); when the head is offered it
// passes S_DISPATCH, S_READ, S_OFFER and S_OUT, and a released head is followed by
// a second S_READ and S_OFFER for the next one. One item at a time; the single registered
// read port of the slot RAM sets the offer path. Reset empties every slot and
// loads the register defaults; descriptor storage itself is not cleared.
module acked_transmit_queue_core import atq_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  ctl_status_t status;
  cmd_e        cmd;

  atq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  atq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_e'(cfg_idx_i)),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import atq_pkg::*;

  localparam int QDepth = DepthDefault;
  localparam int PtrW   = $clog2(QDepth);
  localparam int PhaseItems = 115;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  typedef struct packed {
    logic [15:0] ack;
    logic [15:0] retry;
    logic [3:0]  maxr;
    logic [15:0] nrid;
    logic        rand_nr;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_wdata;

  bit          idle_on = 1'b1;
  int          stall_left = 0;
  int          mismatches = 0;
  out_item_t   results_due[$];

  // Queue state as the block should hold it
  logic [15:0]     ack_ticks, retry_ticks, noreply;
  logic [3:0]      resend_limit;
  logic            q_valid [QDepth];
  logic [15:0]     q_id    [QDepth];
  logic [15:0]     q_len   [QDepth];
  logic [2:0]      q_link  [QDepth];
  logic [PtrW-1:0] wr_pos, rd_pos;
  logic [3:0]      resends;
  logic            ack_wait;
  logic [15:0]     tmr_left;
  logic            tmr_is_ack, tmr_run;

  always #5 clk = ~clk;

  acked_transmit_queue_core #(.DEPTH(QDepth)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  function automatic in_item_t mk_in(action_e a, logic [15:0] id, logic [15:0] len,
                                     logic [2:0] link, logic conn, logic cred,
                                     logic vend, logic ok);
    in_item_t it;
    it.action         = a;
    it.pkt_id         = id;
    it.pkt_len        = len;
    it.link_num       = link;
    it.link_connected = conn;
    it.link_credit    = cred;
    it.link_vendor    = vend;
    it.send_ok        = ok;
    return it;
  endfunction

  function automatic out_item_t mk_out(logic sv, logic [3:0] slot, logic [2:0] link,
                                       logic [15:0] id, logic [15:0] len, logic vend,
                                       logic acc, logic empty, logic awaiting);
    out_item_t r;
    r.send_valid          = sv;
    r.send_slot           = slot;
    r.send_link           = link;
    r.send_id             = id;
    r.send_len            = len;
    r.send_vendor_channel = vend;
    r.push_accepted       = acc;
    r.queue_empty         = empty;
    r.awaiting_ack        = awaiting;
    return r;
  endfunction

  function automatic dir_row_t row(in_item_t it, logic typed, out_item_t want);
    dir_row_t d;
    d.item  = it;
    d.typed = typed;
    d.want  = want;
    return d;
  endfunction

  task automatic tmr_start(input logic [15:0] ticks, input logic is_ack);
    tmr_run    = 1'b1;
    tmr_left   = ticks;
    tmr_is_ack = is_ack;
  endtask

  task automatic retire_head();
    q_valid[rd_pos] = 1'b0;
    rd_pos = rd_pos + 1'b1;
  endtask

  task automatic offer_head(input in_item_t it, input logic free_head, inout out_item_t r);
    if (q_valid[rd_pos]) begin
      if (free_head) begin
        tmr_run  = 1'b0;
        tmr_left = '0;
        retire_head();
        resends  = '0;
        ack_wait = 1'b0;
      end
      if (q_valid[rd_pos] && !ack_wait && it.link_connected) begin
        if (!it.link_credit) begin
          // no credit on the link: drop the head
          retire_head();
          resends = '0;
          tmr_start(NoreplyNextTicks, 1'b0);
        end else if (!it.send_ok) begin
          tmr_start(retry_ticks, 1'b0);
        end else begin
          r.send_valid          = 1'b1;
          r.send_slot           = 4'(rd_pos);
          r.send_link           = q_link[rd_pos];
          r.send_id             = q_id[rd_pos];
          r.send_len            = q_len[rd_pos];
          r.send_vendor_channel = it.link_vendor;
          if (q_id[rd_pos] == noreply) begin
            retire_head();
            tmr_start(NoreplyNextTicks, 1'b0);
          end else begin
            ack_wait = 1'b1;
            tmr_start(ack_ticks, 1'b1);
          end
        end
      end
    end
  endtask

  task automatic txq_step(input in_item_t it, output out_item_t r);
    logic was_ack;
    r = '0;
    case (it.action)
      ACT_PUSH: begin
        if (!q_valid[wr_pos] && it.link_num < LinkCount) begin
          q_valid[wr_pos] = 1'b1;
          q_id[wr_pos]    = it.pkt_id;
          q_len[wr_pos]   = it.pkt_len;
          q_link[wr_pos]  = it.link_num;
          wr_pos = wr_pos + 1'b1;
          r.push_accepted = 1'b1;
          offer_head(it, 1'b0, r);
        end
      end
      ACT_ACK: begin
        if (q_valid[rd_pos]) offer_head(it, q_id[rd_pos] == it.pkt_id, r);
      end
      ACT_TICK: begin
        if (tmr_run) begin
          if (tmr_left > 16'd1) begin
            tmr_left = tmr_left - 1'b1;
          end else begin
            was_ack  = tmr_is_ack;
            tmr_run  = 1'b0;
            tmr_left = '0;
            ack_wait = 1'b0;
            if (q_valid[rd_pos]) begin
              if (was_ack) begin
                if (resends < ResendMax) resends = resends + 1'b1;
                offer_head(it, resends >= resend_limit, r);
              end else begin
                offer_head(it, 1'b0, r);
              end
            end
          end
        end
      end
      default: begin
        tmr_run    = 1'b0;
        tmr_left   = '0;
        tmr_is_ack = 1'b0;
        for (int i = 0; i < QDepth; i++) q_valid[i] = 1'b0;
        wr_pos   = '0;
        rd_pos   = '0;
        resends  = '0;
        ack_wait = 1'b0;
      end
    endcase
    r.queue_empty  = !q_valid[rd_pos];
    r.awaiting_ack = ack_wait;
  endtask

  // Mostly well-formed traffic: acks usually carry the head id, links usually usable
  function automatic in_item_t rand_item();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it = mk_in(ACT_TICK, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               3'($urandom_range(0, 7)), $urandom_range(0, 99) < 88,
               $urandom_range(0, 99) < 92, 1'($urandom_range(0, 1)),
               $urandom_range(0, 99) < 80);
    if (pick < 35) begin
      it.action = ACT_PUSH;
      if ($urandom_range(0, 3) == 0) it.pkt_id = noreply;
    end else if (pick < 55) begin
      it.action = ACT_ACK;
      if (q_valid[rd_pos] && $urandom_range(0, 3) != 0) it.pkt_id = q_id[rd_pos];
    end else if (pick >= 97) begin
      it.action = ACT_CLEAR;
    end
    return it;
  endfunction

  task automatic drive_item(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t pred;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    txq_step(it, pred);
    results_due.push_back(typed ? want : pred);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_ACK_TIMEOUT: ack_ticks    = val;
      CFG_RETRY_DELAY: retry_ticks  = val;
      CFG_MAX_RESENDS: resend_limit = val[3:0];
      default:         noreply      = val;
    endcase
  endtask

  // Wait until every predicted item has come back, then let the block go quiet
  task automatic settle();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (results_due.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic flag(input string what, input logic [15:0] want, input logic [15:0] got);
    $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t e;
    if (results_due.size() == 0) begin
      $display("%0t: unexpected item expected none actual %0h", $time, got);
      mismatches++;
    end else begin
      e = results_due.pop_front();
      if (got.send_valid !== e.send_valid) flag("send_valid", e.send_valid, got.send_valid);
      if (got.send_slot !== e.send_slot) flag("send_slot", e.send_slot, got.send_slot);
      if (got.send_link !== e.send_link) flag("send_link", e.send_link, got.send_link);
      if (got.send_id !== e.send_id) flag("send_id", e.send_id, got.send_id);
      if (got.send_len !== e.send_len) flag("send_len", e.send_len, got.send_len);
      if (got.send_vendor_channel !== e.send_vendor_channel)
        flag("send_vendor_channel", e.send_vendor_channel, got.send_vendor_channel);
      if (got.push_accepted !== e.push_accepted)
        flag("push_accepted", e.push_accepted, got.push_accepted);
      if (got.queue_empty !== e.queue_empty) flag("queue_empty", e.queue_empty, got.queue_empty);
      if (got.awaiting_ack !== e.awaiting_ack)
        flag("awaiting_ack", e.awaiting_ack, got.awaiting_ack);
    end
  endtask

  // Collect results and stall the output in short bursts
  always @(posedge clk) begin
    logic nxt;
    if (rst_n && out_valid && out_ready) check_result(out_item);
    if (stall_left > 0) begin
      stall_left--;
      nxt = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      nxt = 1'b0;
    end else begin
      nxt = 1'b1;
    end
    out_ready <= nxt;
  end

  initial begin
    dir_row_t    dir_tab[$];
    phase_t      plan[6];
    out_item_t   quiet;
    logic [15:0] w;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_ACK_TIMEOUT;
    cfg_wdata = '0;

    ack_ticks    = AckTimeoutReset;
    retry_ticks  = RetryDelayReset;
    resend_limit = MaxResendsReset;
    noreply      = NoreplyIdReset;
    for (int i = 0; i < QDepth; i++) begin
      q_valid[i] = 1'b0;
      q_id[i]    = '0;
      q_len[i]   = '0;
      q_link[i]  = '0;
    end
    wr_pos     = '0;
    rd_pos     = '0;
    resends    = '0;
    ack_wait   = 1'b0;
    tmr_left   = '0;
    tmr_is_ack = 1'b0;
    tmr_run    = 1'b0;

    quiet = mk_out(0, 0, 0, 0, 0, 0, 0, 1, 0);
    dir_tab.push_back(row(mk_in(ACT_TICK, 0, 0, 0, 1, 1, 0, 1), 1, quiet));
    dir_tab.push_back(row(mk_in(ACT_ACK, 16'hFFFF, 0, 0, 1, 1, 0, 1), 1, quiet));
    dir_tab.push_back(row(mk_in(ACT_PUSH, 16'h0000, 16'hFFFF, 3'd7, 1, 1, 1, 1), 1,
                          mk_out(1, 0, 3'd7, 16'h0000, 16'hFFFF, 1, 1, 1, 0)));
    dir_tab.push_back(row(mk_in(ACT_TICK, 0, 0, 0, 1, 1, 0, 1), 1, quiet));
    dir_tab.push_back(row(mk_in(ACT_PUSH, 16'hFFFF, 16'h0000, 3'd0, 0, 1, 0, 1), 1,
                          mk_out(0, 0, 0, 0, 0, 0, 1, 0, 0)));
    dir_tab.push_back(row(mk_in(ACT_ACK, 16'h1234, 0, 0, 1, 1, 0, 0), 0, quiet));
    dir_tab.push_back(row(mk_in(ACT_TICK, 0, 0, 0, 1, 1, 0, 1), 0, quiet));
    dir_tab.push_back(row(mk_in(ACT_ACK, 16'hFFFF, 0, 0, 1, 1, 0, 1), 1, quiet));
    dir_tab.push_back(row(mk_in(ACT_PUSH, 16'h5A5A, 16'h0102, 3'd3, 1, 1, 0, 1), 0, quiet));
    dir_tab.push_back(row(mk_in(ACT_PUSH, 16'h1111, 16'h0040, 3'd5, 1, 0, 0, 1), 0, quiet));
    dir_tab.push_back(row(mk_in(ACT_ACK, 16'h5A5A, 0, 0, 1, 0, 0, 1), 0, quiet));
    dir_tab.push_back(row(mk_in(ACT_TICK, 0, 0, 0, 1, 1, 0, 1), 0, quiet));
    dir_tab.push_back(row(mk_in(ACT_PUSH, 16'h2222, 16'h0800, 3'd1, 1, 1, 1, 1), 0, quiet));
    dir_tab.push_back(row(mk_in(ACT_ACK, 16'h2222, 0, 0, 0, 1, 0, 1), 0, quiet));
    dir_tab.push_back(row(mk_in(ACT_PUSH, 16'h3333, 16'h0011, 3'd6, 1, 1, 0, 1), 0, quiet));
    dir_tab.push_back(row(mk_in(ACT_PUSH, 16'h4444, 16'h0022, 3'd4, 1, 1, 1, 1), 0, quiet));
    dir_tab.push_back(row(mk_in(ACT_CLEAR, 0, 0, 0, 1, 1, 0, 1), 1, quiet));
    dir_tab.push_back(row(mk_in(ACT_PUSH, 16'h0000, 16'h0007, 3'd2, 0, 1, 0, 1), 1,
                          mk_out(0, 0, 0, 0, 0, 0, 1, 0, 0)));
    dir_tab.push_back(row(mk_in(ACT_ACK, 16'h0000, 0, 0, 1, 1, 0, 1), 0, quiet));
    dir_tab.push_back(row(mk_in(ACT_TICK, 0, 0, 0, 1, 1, 0, 1), 0, quiet));

    plan[0] = {16'd0,     16'd0,     4'd1,  16'h0000, 1'b0};
    plan[1] = {16'd3,     16'd2,     4'd2,  16'hFFFF, 1'b0};
    plan[2] = {16'hFFFF,  16'hFFFF,  4'd15, 16'h0000, 1'b1};
    plan[3] = {16'd1,     16'd5,     4'd15, 16'h0000, 1'b1};
    plan[4] = {16'd7,     16'd1,     4'd3,  16'h0000, 1'b1};
    plan[5] = {16'd2,     16'd0,     4'd1,  16'h0000, 1'b1};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed part runs on the reset values of the registers
    foreach (dir_tab[i]) drive_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

    for (int p = 0; p < 6; p++) begin
      settle();
      if (p == 5) idle_on = 1'b0;
      cfg_write(CFG_ACK_TIMEOUT, plan[p].ack);
      cfg_write(CFG_RETRY_DELAY, plan[p].retry);
      // upper bits are don't-care for the resend limit
      w = 16'($urandom_range(0, 65535));
      w[3:0] = plan[p].maxr;
      cfg_write(CFG_MAX_RESENDS, w);
      cfg_write(CFG_NOREPLY_ID,
                plan[p].rand_nr ? 16'($urandom_range(0, 65535)) : plan[p].nrid);
      cfg_we <= 1'b0;
      for (int n = 0; n < PhaseItems; n++) drive_item(rand_item(), 1'b0, quiet);
    end

    settle();
    if (results_due.size() != 0) begin
      $display("%0t: pending items expected 0 actual %0d", $time, results_due.size());
      mismatches += results_due.size();
    end
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
